[src/interval_timer_channel_rate_generator_unit_defines.svh]
// Assertion macros for the interval timer channel RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef INTERVAL_TIMER_CHANNEL_RATE_GENERATOR_UNIT_DEFINES_SVH
`define INTERVAL_TIMER_CHANNEL_RATE_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ITCR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ITCR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/itcr_pkg.sv]
// Types and constants of the interval timer channel (rate-generator mode).
// No dependencies; used by the RTL modules through scoped names.
package itcr_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_CTRL  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  // Control word fields
  localparam logic [1:0] CHANNEL_0    = 2'b00;
  localparam logic [1:0] ACCESS_LATCH = 2'b00;
  localparam logic [1:0] ACCESS_LOHI  = 2'b11;
  localparam logic [1:0] MODE_RATE    = 2'b10;  // low two bits of the mode field
  localparam logic       BCD_OFF      = 1'b0;

  localparam logic [15:0] COUNT_ONE = 16'd1;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       irq_pulse;
    logic       running;
  } result_t;

endpackage

[src/itcr_if.sv]
// Request and result channel interfaces with valid/ready handshake.
// Payload layout follows the item and result fields of itcr_pkg.
interface itcr_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data;

  modport source (output valid, output opcode, output data, input ready);
  modport sink   (input valid, input opcode, input data, output ready);
endinterface

interface itcr_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       irq_pulse;
  logic       running;

  modport source (output valid, output read_byte, output irq_pulse, output running,
                  input ready);
  modport sink   (input valid, input read_byte, input irq_pulse, input running,
                  output ready);
endinterface

[src/interval_timer_channel_rate_generator_unit.sv]
// Interval timer channel 0, rate-generator mode, one request per cycle unless stalled.
// A request accepted into the input register has its result shown from the result register.
// Stages: input register, one-step update, result register.
// A full result register stalls the input side only when it is not being drained.
// Reset (synchronous, rst high) clears all channel state and empties both registers.
module interval_timer_channel_rate_generator_unit (
  input  logic           clk,
  input  logic           rst,
  itcr_item_if.sink      cmd,
  itcr_result_if.source  result
);

  logic              item_valid;
  itcr_pkg::item_t   item;
  itcr_pkg::result_t res;
  logic              out_free;
  logic              step;

  // Advance the held request when the result register can take its result.
  assign step = item_valid && out_free;

  itcr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .advance    (out_free),
    .item_valid (item_valid),
    .item       (item)
  );

  itcr_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (item),
    .res  (res)
  );

  itcr_out_reg u_out_reg (
    .clk    (clk),
    .rst    (rst),
    .load   (step),
    .res    (res),
    .free   (out_free),
    .result (result)
  );

endmodule

[src/itcr_in_reg.sv]
// Input register: takes one request per cycle while ready and holds it for the core.
// Depends on itcr_pkg and itcr_item_if.
module itcr_in_reg (
  input  logic                clk,
  input  logic                rst,
  itcr_item_if.sink           cmd,
  input  logic                advance,
  output logic                item_valid,
  output itcr_pkg::item_t     item
);

  logic            valid_q;
  itcr_pkg::item_t item_q;

  // Accept when empty or when the held request moves on this cycle.
  assign cmd.ready  = !valid_q || advance;
  assign item_valid = valid_q;
  assign item       = item_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (cmd.ready) begin
      valid_q <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      item_q.opcode <= cmd.opcode;
      item_q.data   <= cmd.data;
    end
  end

endmodule

[src/itcr_core.sv]
// Channel state and single-step update for one request.
// Depends on itcr_pkg and the assertion macros header.
`include "interval_timer_channel_rate_generator_unit_defines.svh"

module itcr_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  itcr_pkg::item_t   item,
  output itcr_pkg::result_t res
);

  logic [15:0] reload_value,    reload_value_next;
  logic [15:0] current_count,   current_count_next;
  logic [15:0] latched_count,   latched_count_next;
  logic        latch_held,      latch_held_next;
  logic        write_high_next, write_high_next_next;
  logic        read_high_next,  read_high_next_next;
  logic [7:0]  low_byte_hold,   low_byte_hold_next;
  logic        armed,           armed_next;
  logic        load_pending,    load_pending_next;

  logic [1:0]  cw_channel;
  logic [1:0]  cw_access;
  logic [2:0]  cw_mode;
  logic        cw_bcd;
  logic [15:0] read_src;

  assign cw_channel = item.data[7:6];
  assign cw_access  = item.data[5:4];
  assign cw_mode    = item.data[3:1];
  assign cw_bcd     = item.data[0];
  assign read_src   = latch_held ? latched_count : current_count;

  always_comb begin
    reload_value_next    = reload_value;
    current_count_next   = current_count;
    latched_count_next   = latched_count;
    latch_held_next      = latch_held;
    write_high_next_next = write_high_next;
    read_high_next_next  = read_high_next;
    low_byte_hold_next   = low_byte_hold;
    armed_next           = armed;
    load_pending_next    = load_pending;
    res.read_byte        = 8'd0;
    res.irq_pulse        = 1'b0;

    unique case (itcr_pkg::opcode_t'(item.opcode))
      itcr_pkg::OP_TICK: begin
        if (armed) begin
          if (load_pending) begin
            current_count_next = reload_value;
            load_pending_next  = 1'b0;
          end else if (current_count == itcr_pkg::COUNT_ONE) begin
            current_count_next = reload_value;
            res.irq_pulse      = 1'b1;
          end else begin
            // wraps from zero to all ones, giving the 65536-tick period
            current_count_next = current_count - itcr_pkg::COUNT_ONE;
          end
        end
      end
      itcr_pkg::OP_CTRL: begin
        if (cw_channel == itcr_pkg::CHANNEL_0) begin
          if (cw_access == itcr_pkg::ACCESS_LATCH) begin
            if (!latch_held) begin
              latched_count_next = current_count;
              latch_held_next    = 1'b1;
            end
          end else if (cw_access == itcr_pkg::ACCESS_LOHI &&
                       cw_mode[1:0] == itcr_pkg::MODE_RATE &&
                       cw_bcd == itcr_pkg::BCD_OFF) begin
            // stop counting and wait for a fresh reload
            armed_next           = 1'b0;
            load_pending_next    = 1'b0;
            write_high_next_next = 1'b0;
            read_high_next_next  = 1'b0;
            latch_held_next      = 1'b0;
          end
        end
      end
      itcr_pkg::OP_WRITE: begin
        if (!write_high_next) begin
          low_byte_hold_next   = item.data;
          write_high_next_next = 1'b1;
        end else begin
          reload_value_next    = {item.data, low_byte_hold};
          write_high_next_next = 1'b0;
          if (!armed) begin
            armed_next        = 1'b1;
            load_pending_next = 1'b1;
          end
        end
      end
      itcr_pkg::OP_READ: begin
        if (!read_high_next) begin
          res.read_byte       = read_src[7:0];
          read_high_next_next = 1'b1;
        end else begin
          res.read_byte       = read_src[15:8];
          read_high_next_next = 1'b0;
          latch_held_next     = 1'b0;
        end
      end
      default: ;
    endcase

    res.running = armed_next && !load_pending_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reload_value    <= '0;
      current_count   <= '0;
      latched_count   <= '0;
      latch_held      <= 1'b0;
      write_high_next <= 1'b0;
      read_high_next  <= 1'b0;
      low_byte_hold   <= '0;
      armed           <= 1'b0;
      load_pending    <= 1'b0;
    end else if (step) begin
      reload_value    <= reload_value_next;
      current_count   <= current_count_next;
      latched_count   <= latched_count_next;
      latch_held      <= latch_held_next;
      write_high_next <= write_high_next_next;
      read_high_next  <= read_high_next_next;
      low_byte_hold   <= low_byte_hold_next;
      armed           <= armed_next;
      load_pending    <= load_pending_next;
    end
  end

  `ITCR_ASSERT_NOW(a_irq_only_on_tick, clk, rst,
                   step && res.irq_pulse,
                   item.opcode == itcr_pkg::OP_TICK && armed && !load_pending,
                   "interrupt raised outside a counting tick")
  `ITCR_ASSERT_NOW(a_byte_only_on_read, clk, rst,
                   step && res.read_byte != 8'd0,
                   item.opcode == itcr_pkg::OP_READ,
                   "read byte driven for a non-read request")
  `ITCR_ASSERT_NEXT(a_load_on_tick, clk, rst,
                    step && item.opcode == itcr_pkg::OP_TICK && armed && load_pending,
                    armed && !load_pending && current_count == $past(reload_value),
                    "pending reload not taken on tick")
  `ITCR_ASSERT_NEXT(a_running_matches, clk, rst,
                    step,
                    $past(res.running) == (armed && !load_pending),
                    "running flag disagrees with channel state")

endmodule

[src/itcr_out_reg.sv]
// Result register: holds one result until the downstream side takes it.
// Depends on itcr_pkg and itcr_result_if.
module itcr_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  itcr_pkg::result_t   res,
  output logic                free,
  itcr_result_if.source       result
);

  logic              valid_q;
  itcr_pkg::result_t res_q;

  assign free             = !valid_q || result.ready;
  assign result.valid     = valid_q;
  assign result.read_byte = res_q.read_byte;
  assign result.irq_pulse = res_q.irq_pulse;
  assign result.running   = res_q.running;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (free) begin
      valid_q <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

endmodule
